@@ rtl/mdm_pkg.sv @@
package mdm_pkg;

  localparam int unsigned SumW = 48;

  // One channel's state as it travels down the ring.
  typedef struct packed {
    logic [31:0]            phase;
    logic [31:0]            step;
    logic signed [SumW-1:0] re;
    logic signed [SumW-1:0] im;
  } chan_t;

  // Q30 coefficients of the odd sine polynomial.
  localparam logic [30:0] K1 = 31'd1686629713;
  localparam logic [30:0] K3 = 31'd693598669;
  localparam logic [30:0] K5 = 31'd85569305;
  localparam logic [30:0] K7 = 31'd5026994;

  // Configuration register indexes.
  localparam logic [2:0] REG_ACTIVE    = 3'd0;
  localparam logic [2:0] REG_SPF       = 3'd1;
  localparam logic [2:0] REG_CHANNELS  = 3'd2;
  localparam logic [2:0] REG_FRAME_DMP = 3'd3;
  localparam logic [2:0] REG_AMP_DMP   = 3'd4;
  localparam logic [2:0] REG_GAIN      = 3'd5;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  function automatic logic signed [SumW-1:0] sat_add(input logic signed [SumW-1:0] a,
                                                     input logic signed [31:0] b);
    logic signed [SumW:0] s;
    s = (SumW+1)'(a) + (SumW+1)'(b);
    if (s[SumW] != s[SumW-1]) begin
      return s[SumW] ? SumMin : SumMax;
    end
    return s[SumW-1:0];
  endfunction

endpackage

@@ rtl/multi_tone_phase_demodulator.sv @@
// Bank of CHANNELS complex demodulators fed by one audio stream. Each sample
// (req_type 0) taken while active raises the peak level, is normalized to
// Q1.15 by a 16-step restoring divider unless the peak is zero, and is then
// mixed against every channel in use: the channel states sit in a ring of
// cells that rotates one position per channel visited, and the head of the
// ring goes through a shared mix unit (phase advance, polynomial sine/cosine,
// two products, saturating add). Idle channels are shifted past unmixed. At a
// frame end every channel is scaled for output and damped on its way round
// the ring, and this waits while out_stall_i holds a result back.
// A load word (req_type 1) sets a channel's step and clears its phase and
// sums. in_stall_o is high while a word is being worked on.
// Results come out one per cycle at most from a single output register, so
// the input may accept again while the last result waits to be taken.
module multi_tone_phase_demodulator #(
  parameter int unsigned CHANNELS    = 8,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [15:0]            cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   req_type_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [2:0]             channel_i,
  input  logic [31:0]            phase_step_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             out_channel_o,
  output logic signed [31:0]     phase_real_o,
  output logic signed [31:0]     phase_imag_o,
  output logic                   last_o
);
  import mdm_pkg::*;

  localparam int unsigned IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CW = $clog2(CHANNELS + 1) + 4;
  localparam int unsigned SB = SAMPLE_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_WALK = 3'd2;
  localparam logic [2:0] ST_MIX  = 3'd3;
  localparam logic [2:0] ST_FMUL = 3'd4;
  localparam logic [2:0] ST_FOUT = 3'd5;
  localparam logic [2:0] ST_PEAK = 3'd6;

  // configuration
  logic        active_q;
  logic [15:0] spf_q, fdamp_q, adamp_q, gain_q;
  logic [3:0]  nuse_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      spf_q    <= 16'd22050;
      nuse_q   <= '0;
      fdamp_q  <= 16'd58982;
      adamp_q  <= 16'd58982;
      gain_q   <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ACTIVE:    active_q <= cfg_data_i[0];
        REG_SPF:       spf_q    <= cfg_data_i;
        REG_CHANNELS:  nuse_q   <= cfg_data_i[3:0];
        REG_FRAME_DMP: fdamp_q  <= cfg_data_i;
        REG_AMP_DMP:   adamp_q  <= cfg_data_i;
        REG_GAIN:      gain_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control state
  logic [2:0]         state_q, state_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [SB-1:0]      peak_q, peak_d;
  logic [15:0]        cd_q, cd_d;
  logic [SB-1:0]      rem_q, rem_d;
  logic [3:0]         dcnt_q, dcnt_d;
  logic [15:0]        quo_q, quo_d;
  logic               neg_q, neg_d;
  logic signed [15:0] norm_q, norm_d;
  logic               out_valid_q;

  // ring
  chan_t ring [CHANNELS];
  chan_t shift_data, mix_res;
  logic  shift_en, load_fire, mix_start, mix_done, emit_fire;

  logic signed [31:0]     sc_re, sc_im;
  logic signed [SumW-1:0] dm_re, dm_im;

  logic [CW-1:0] nch, idx_w;
  logic          idx_act, idx_last, out_free;

  assign nch      = (CW'(nuse_q) < CW'(CHANNELS)) ? CW'(nuse_q) : CW'(CHANNELS);
  assign idx_w    = CW'(idx_q);
  assign idx_act  = idx_w < nch;
  assign idx_last = idx_w == CW'(CHANNELS - 1);
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o = state_q != ST_IDLE;
  assign load_fire  = in_valid_i && !in_stall_o && req_type_i;

  for (genvar k = 0; k < CHANNELS; k++) begin : g_cell
    chan_t din;
    if (k == CHANNELS - 1) begin : g_tail
      assign din = shift_data;
    end else begin : g_mid
      assign din = ring[k+1];
    end
    mdm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift_en),
      .din_i   (din),
      .load_i  (load_fire && (32'(channel_i) == k)),
      .step_i  (phase_step_i),
      .q_o     (ring[k])
    );
  end

  mdm_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mix_start),
    .chan_i  (ring[0]),
    .norm_i  (norm_q),
    .done_o  (mix_done),
    .chan_o  (mix_res)
  );

  mdm_scale u_scale (
    .clk_i     (clk_i),
    .re_i      (ring[0].re),
    .im_i      (ring[0].im),
    .gain_i    (gain_q),
    .damp_i    (fdamp_q),
    .out_re_o  (sc_re),
    .out_im_o  (sc_im),
    .damp_re_o (dm_re),
    .damp_im_o (dm_im)
  );

  // sample magnitude and divider step
  logic [SB-1:0]      mag, peak_new;
  logic [SB:0]        trial;
  logic               ge;
  logic [SB+15:0]     peak_prod;

  assign mag       = sample_i[SB-1] ? (~sample_i + SB'(1)) : sample_i;
  assign peak_new  = (mag > peak_q) ? mag : peak_q;
  assign trial     = (dcnt_q == 4'd0) ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign ge        = trial >= {1'b0, peak_q};
  assign peak_prod = (SB+16)'(peak_q) * (SB+16)'(adamp_q);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    peak_d     = peak_q;
    cd_d       = cd_q;
    rem_d      = rem_q;
    dcnt_d     = dcnt_q;
    quo_d      = quo_q;
    neg_d      = neg_q;
    norm_d     = norm_q;
    shift_en   = 1'b0;
    shift_data = ring[0];
    mix_start  = 1'b0;
    emit_fire  = 1'b0;
    unique case (state_q) inside
      ST_IDLE: begin
        if (in_valid_i && !req_type_i && active_q) begin
          peak_d = peak_new;
          if (peak_new != '0) begin
            rem_d   = mag;
            dcnt_d  = '0;
            neg_d   = sample_i[SB-1];
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_d  = ge ? SB'(trial - {1'b0, peak_q}) : trial[SB-1:0];
        quo_d  = {quo_q[14:0], ge};
        dcnt_d = dcnt_q + 4'd1;
        if (dcnt_q == 4'd15) begin
          if (neg_q) begin
            norm_d = -$signed(quo_d);
          end else begin
            norm_d = quo_d[15] ? 16'sd32767 : $signed(quo_d);
          end
          idx_d   = '0;
          state_d = ST_WALK;
        end
      end
      ST_WALK, ST_MIX: begin
        if (state_q == ST_WALK && idx_act) begin
          mix_start = 1'b1;
          state_d   = ST_MIX;
        end else if (state_q == ST_WALK || mix_done) begin
          shift_en = 1'b1;
          if (state_q == ST_MIX) begin
            shift_data = mix_res;
          end
          idx_d = idx_q + IW'(1);
          if (idx_last) begin
            idx_d = '0;
            if (cd_q == '0) begin
              state_d = ST_FMUL;
            end else begin
              cd_d    = cd_q - 16'd1;
              state_d = ST_IDLE;
            end
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_FMUL: begin
        // scale unit registers the head this cycle
        state_d = ST_FOUT;
      end
      ST_FOUT: begin
        if (!idx_act || out_free) begin
          emit_fire        = idx_act;
          shift_en         = 1'b1;
          shift_data.re    = dm_re;
          shift_data.im    = dm_im;
          idx_d            = idx_q + IW'(1);
          state_d          = ST_FMUL;
          if (idx_last) begin
            idx_d   = '0;
            state_d = ST_PEAK;
          end
        end
      end
      ST_PEAK: begin
        peak_d  = peak_prod[SB+15:16];
        cd_d    = spf_q;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      peak_q  <= '0;
      cd_q    <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      peak_q  <= peak_d;
      cd_q    <= cd_d;
      dcnt_q  <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    neg_q  <= neg_d;
    norm_q <= norm_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_channel_o <= idx_w[2:0];
      phase_real_o  <= sc_re;
      phase_imag_o  <= sc_im;
      last_o        <= (idx_w + CW'(1)) == nch;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/mdm_cell.sv @@
module mdm_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  mdm_pkg::chan_t din_i,
  input  logic          load_i,
  input  logic [31:0]   step_i,
  output mdm_pkg::chan_t q_o
);
  import mdm_pkg::*;

  chan_t chan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= '0;
    end else if (load_i) begin
      chan_q.phase <= '0;
      chan_q.step  <= step_i;
      chan_q.re    <= '0;
      chan_q.im    <= '0;
    end else if (shift_i) begin
      chan_q <= din_i;
    end
  end

  assign q_o = chan_q;

endmodule

@@ rtl/mdm_mix.sv @@
module mdm_mix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  mdm_pkg::chan_t     chan_i,
  input  logic signed [15:0] norm_i,
  output logic               done_o,
  output mdm_pkg::chan_t     chan_o
);
  import mdm_pkg::*;

  logic              busy_q;
  logic [2:0]        step_q;
  logic [31:0]       ph_q;
  logic [30:0]       z2a_q, z2b_q, pa_q, pb_q;
  logic signed [15:0] cos_q, sin_q;
  logic signed [31:0] pre_q, pim_q;

  logic [15:0] za, zb;
  logic [31:0] sqa, sqb;
  logic [30:0] kk, opa, opb;
  logic [61:0] mula, mulb;
  logic [46:0] ra, rb;
  logic signed [15:0] sa, ca;

  assign za = {1'b0, ph_q[29:15]};
  assign zb = 16'd32768 - za;
  assign sqa = za * za;
  assign sqb = zb * zb;

  always_comb begin
    case (step_q)
      3'd2:    kk = K5;
      3'd3:    kk = K3;
      default: kk = K1;
    endcase
    opa = (step_q == 3'd2) ? K7 : pa_q;
    opb = (step_q == 3'd2) ? K7 : pb_q;
  end

  assign mula = 62'(opa) * 62'(z2a_q);
  assign mulb = 62'(opb) * 62'(z2b_q);
  assign ra   = 47'(pa_q) * 47'(za);
  assign rb   = 47'(pb_q) * 47'(zb);
  assign sa   = (ra[46:30] > 17'd32767) ? 16'sd32767 : $signed(ra[45:30]);
  assign ca   = (rb[46:30] > 17'd32767) ? 16'sd32767 : $signed(rb[45:30]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= 3'd1;
    end else if (busy_q) begin
      if (step_q == 3'd7) begin
        busy_q <= 1'b0;
        step_q <= '0;
      end else begin
        step_q <= step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ph_q <= chan_i.phase + chan_i.step;
    end
    case (step_q) inside
      3'd1: begin
        z2a_q <= sqa[30:0];
        z2b_q <= sqb[30:0];
      end
      3'd2, 3'd3, 3'd4: begin
        pa_q <= kk - mula[60:30];
        pb_q <= kk - mulb[60:30];
      end
      3'd5: begin
        // quadrant fold
        case (ph_q[31:30])
          2'd0:    begin cos_q <= ca;  sin_q <= sa;  end
          2'd1:    begin cos_q <= -sa; sin_q <= ca;  end
          2'd2:    begin cos_q <= -ca; sin_q <= -sa; end
          default: begin cos_q <= sa;  sin_q <= -ca; end
        endcase
      end
      3'd6: begin
        pre_q <= cos_q * norm_i;
        pim_q <= sin_q * norm_i;
      end
      default: ;
    endcase
  end

  assign done_o       = busy_q && (step_q == 3'd7);
  assign chan_o.phase = ph_q;
  assign chan_o.step  = chan_i.step;
  assign chan_o.re    = sat_add(chan_i.re, pre_q);
  assign chan_o.im    = sat_add(chan_i.im, pim_q);

endmodule

@@ rtl/mdm_scale.sv @@
module mdm_scale (
  input  logic                           clk_i,
  input  logic signed [mdm_pkg::SumW-1:0] re_i,
  input  logic signed [mdm_pkg::SumW-1:0] im_i,
  input  logic [15:0]                    gain_i,
  input  logic [15:0]                    damp_i,
  output logic signed [31:0]             out_re_o,
  output logic signed [31:0]             out_im_o,
  output logic signed [mdm_pkg::SumW-1:0] damp_re_o,
  output logic signed [mdm_pkg::SumW-1:0] damp_im_o
);
  import mdm_pkg::*;

  logic [1:0]  neg_q;
  logic [39:0] hg_q [2], lg_q [2], hd_q [2], ld_q [2];
  logic [47:0] mag [2];
  logic signed [48:0] rg [2], rd [2];
  logic signed [31:0] og [2];

  assign mag[0] = re_i[47] ? 48'(-re_i) : re_i;
  assign mag[1] = im_i[47] ? 48'(-im_i) : im_i;

  // partial products on 24-bit halves of the magnitude
  always_ff @(posedge clk_i) begin
    neg_q <= {im_i[47], re_i[47]};
    for (int k = 0; k < 2; k++) begin
      hg_q[k] <= 40'(mag[k][47:24]) * 40'(gain_i);
      lg_q[k] <= 40'(mag[k][23:0]) * 40'(gain_i);
      hd_q[k] <= 40'(mag[k][47:24]) * 40'(damp_i);
      ld_q[k] <= 40'(mag[k][23:0]) * 40'(damp_i);
    end
  end

  always_comb begin
    logic [63:0] fg, fd;
    for (int k = 0; k < 2; k++) begin
      fg = {hg_q[k], 24'b0} + 64'(lg_q[k]);
      fd = {hd_q[k], 24'b0} + 64'(ld_q[k]);
      rg[k] = neg_q[k] ? -$signed({1'b0, fg[63:16]}) : $signed({1'b0, fg[63:16]});
      rd[k] = neg_q[k] ? -$signed({1'b0, fd[63:16]}) : $signed({1'b0, fd[63:16]});
      if (rg[k][48:31] == '0 || rg[k][48:31] == '1) begin
        og[k] = rg[k][31:0];
      end else begin
        og[k] = rg[k][48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
    end
  end

  assign out_re_o  = og[0];
  assign out_im_o  = og[1];
  assign damp_re_o = rd[0][47:0];
  assign damp_im_o = rd[1][47:0];

endmodule

@@ tb/sv/multi_tone_phase_demodulator_tb.sv @@
`timescale 1ns / 100ps

module multi_tone_phase_demodulator_tb;
  import mdm_pkg::*;

  localparam int NumChan   = 8;
  localparam int SettleCyc = 300;   // worst word: mixing on every channel plus a frame dump
  localparam int StuckLim  = 20000; // cycles without any handshake before giving up

  typedef struct {
    logic [2:0]         ch;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               last;
  } phase_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               req_type_i = 1'b0;
  logic [15:0]        sample_i = '0;
  logic [2:0]         channel_i = '0;
  logic [31:0]        phase_step_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         out_channel_o;
  logic signed [31:0] phase_real_o;
  logic signed [31:0] phase_imag_o;
  logic               last_o;

  multi_tone_phase_demodulator dut (.*);

  always #1 clk_i = ~clk_i;

  // Shadow copy of the block: registers and per-channel state.
  logic        m_active;
  logic [15:0] m_spf;
  logic [3:0]  m_nchan;
  logic [15:0] m_frame_dmp, m_amp_dmp, m_gain;
  logic [31:0] m_phase [NumChan];
  logic [31:0] m_step [NumChan];
  longint      m_re [NumChan];
  longint      m_im [NumChan];
  logic [15:0] m_peak, m_countdown;

  phase_result_t pending_results[$];
  int  words_sent, results_seen, frames_seen, errors;
  bit  quiet;     // no idling on either side while set
  int  stuck_cnt;

  function automatic longint unsigned sine_q15(longint unsigned z);
    longint unsigned z2, p, r;
    z2 = z * z;
    p = longint'(K7);
    p = longint'(K5) - ((p * z2) >> 30);
    p = longint'(K3) - ((p * z2) >> 30);
    p = longint'(K1) - ((p * z2) >> 30);
    r = (p * z) >> 30;
    return (r > 32767) ? 32767 : r;
  endfunction

  function automatic void osc_lookup(input logic [31:0] ph, output longint c, output longint s);
    longint unsigned z;
    longint sa, ca;
    z  = longint'(ph[29:15]);
    sa = longint'(sine_q15(z));
    ca = longint'(sine_q15(32768 - z));
    case (ph[31:30])
      2'd0: begin c = ca;  s = sa;  end
      2'd1: begin c = -sa; s = ca;  end
      2'd2: begin c = -ca; s = -sa; end
      default: begin c = sa; s = -ca; end
    endcase
  endfunction

  function automatic longint sum_clip(longint v);
    longint hi, lo;
    hi = longint'(SumMax);
    lo = longint'(SumMin);
    return (v > hi) ? hi : (v < lo) ? lo : v;
  endfunction

  // sign(v) * ((|v| * g) >> 16)
  function automatic longint gain_q16(longint v, logic [15:0] g);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = (m * g) >> 16;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic signed [31:0] word_clip(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic void model_write(logic [2:0] idx, logic [15:0] val);
    case (idx)
      REG_ACTIVE:    m_active    = val[0];
      REG_SPF:       m_spf       = val;
      REG_CHANNELS:  m_nchan     = val[3:0];
      REG_FRAME_DMP: m_frame_dmp = val;
      REG_AMP_DMP:   m_amp_dmp   = val;
      REG_GAIN:      m_gain      = val;
      default: ;
    endcase
  endfunction

  // Work out what one accepted word does; queue any frame results.
  function automatic void predict_word(logic rt, logic [15:0] smp, logic [2:0] ch,
                                       logic [31:0] stp);
    longint s, n, c, sn;
    longint unsigned mag, q;
    int nch;
    phase_result_t r;
    if (rt) begin
      m_step[ch] = stp; m_phase[ch] = '0; m_re[ch] = 0; m_im[ch] = 0;
      return;
    end
    if (!m_active) return;
    s   = longint'(signed'(smp));
    mag = (s < 0) ? -s : s;
    if (mag > m_peak) m_peak = mag[15:0];
    if (m_peak == 0) return;   // zero peak: sample skipped
    q = (mag << 15) / m_peak;
    n = (s < 0) ? -longint'(q) : ((q > 32767) ? 32767 : longint'(q));
    nch = (m_nchan < NumChan) ? m_nchan : NumChan;
    for (int i = 0; i < nch; i++) begin
      m_phase[i] += m_step[i];
      osc_lookup(m_phase[i], c, sn);
      m_re[i] = sum_clip(m_re[i] + c * n);
      m_im[i] = sum_clip(m_im[i] + sn * n);
    end
    if (m_countdown == 0) begin
      for (int i = 0; i < nch; i++) begin
        r.ch   = i[2:0];
        r.re   = word_clip(gain_q16(m_re[i], m_gain));
        r.im   = word_clip(gain_q16(m_im[i], m_gain));
        r.last = (i + 1 == nch);
        pending_results = {pending_results, r};
      end
      for (int i = 0; i < NumChan; i++) begin
        m_re[i] = gain_q16(m_re[i], m_frame_dmp);
        m_im[i] = gain_q16(m_im[i], m_frame_dmp);
      end
      m_peak = 16'((32'(m_peak) * m_amp_dmp) >> 16);
      m_countdown = m_spf;
      frames_seen++;
    end else begin
      m_countdown = m_countdown - 1'b1;
    end
  endfunction

  // Result side: random stall, compare each taken word against the oldest prediction.
  always @(posedge clk_i) begin
    phase_result_t e;
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result on channel %0d", out_channel_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_channel_o !== e.ch) begin
          $error("out_channel: expected %0d, got %0d", e.ch, out_channel_o); errors++;
        end
        if (phase_real_o !== e.re) begin
          $error("phase_real: expected %0d, got %0d", e.re, phase_real_o); errors++;
        end
        if (phase_imag_o !== e.im) begin
          $error("phase_imag: expected %0d, got %0d", e.im, phase_imag_o); errors++;
        end
        if (last_o !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, last_o); errors++;
        end
      end
    end
    out_stall_i <= !quiet && ($urandom_range(99) < 18);
  end

  // Watchdog on handshake activity.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i
        || pending_results.size() == 0 && !in_valid_i)
      stuck_cnt <= 0;
    else if (stuck_cnt >= StuckLim) begin
      $display("Mismatches found");
      $finish;
    end else
      stuck_cnt <= stuck_cnt + 1;
  end

  // Called at a rising edge; returns at the edge where the word was taken.
  task automatic send_word(logic rt, logic [15:0] smp, logic [2:0] ch, logic [31:0] stp);
    if (!quiet && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 40);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= rt;
    sample_i     <= smp;
    channel_i    <= ch;
    phase_step_i <= stp;
    do @(posedge clk_i); while (in_stall_o);
    predict_word(rt, smp, ch, stp);
    words_sent++;
  endtask

  task automatic send_sample(logic [15:0] smp);
    send_word(1'b0, smp, 3'($urandom), $urandom);
  endtask

  task automatic load_step(logic [2:0] ch, logic [31:0] stp);
    send_word(1'b1, 16'($urandom), ch, stp);
  endtask

  // Let all results drain and the block go quiet before touching registers.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller drops it after its last write.
  task automatic reg_write(logic [2:0] idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    model_write(idx, val);
  endtask

  task automatic setup(logic act, logic [15:0] spf, logic [3:0] nch, logic [15:0] fd,
                       logic [15:0] ad, logic [15:0] g);
    drain();
    reg_write(REG_ACTIVE, 16'(act));
    reg_write(REG_SPF, spf);
    reg_write(REG_CHANNELS, 16'(nch));
    reg_write(REG_FRAME_DMP, fd);
    reg_write(REG_AMP_DMP, ad);
    reg_write(REG_GAIN, g);
    cfg_we_i <= 1'b0;
  endtask

  // Samples while inactive do nothing; loads still land.
  task automatic test_inactive();
    send_sample(16'h7fff);
    send_sample(16'h8000);
    for (int i = 0; i < NumChan; i++) load_step(i[2:0], 32'h0100_0000 * (i + 1));
  endtask

  // Zero peak skips the sample; then full-scale and sign edge cases at step extremes.
  task automatic test_extremes();
    setup(1'b1, 16'd1, 4'd8, 16'hffff, 16'hffff, 16'hffff);
    send_sample(16'h0000);
    load_step(3'd0, 32'h0000_0000);
    load_step(3'd1, 32'hffff_ffff);
    load_step(3'd2, 32'h4000_0000);
    load_step(3'd3, 32'h8000_0000);
    load_step(3'd4, 32'hc000_0000);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'h7fff);
    send_sample(16'hffff);
    send_sample(16'h0001);
    send_sample(16'h0000);
    send_sample(16'h8000);
  endtask

  // No channels: frames still damp and reload. Then the 4-bit count above 8 is capped.
  // Zero damping drops the peak to zero, so the next zero sample is skipped.
  task automatic test_channel_count();
    setup(1'b1, 16'd2, 4'd0, 16'd0, 16'd0, 16'd0);
    repeat (4) send_sample(16'($urandom));
    send_sample(16'h0000);
    setup(1'b1, 16'd1, 4'd15, 16'd32768, 16'd65535, 16'd1);
    repeat (4) send_sample(16'($urandom));
  endtask

  // Indexes past the list are ignored.
  task automatic test_bad_index();
    drain();
    reg_write(3'd6, 16'hffff);
    reg_write(3'd7, 16'h0000);
    cfg_we_i <= 1'b0;
    repeat (3) send_sample(16'($urandom));
  endtask

  task automatic test_random(int items, int phases);
    for (int p = 0; p < phases; p++) begin
      quiet = (p == 1);
      setup(1'b1, 16'($urandom_range(1, 5)), 4'($urandom_range(1, 9)), 16'($urandom),
            16'($urandom_range(40000, 65535)), 16'($urandom));
      for (int i = 0; i < items / phases; i++) begin
        if ($urandom_range(99) < 15) load_step(3'($urandom), $urandom);
        else send_sample(16'($urandom));
      end
    end
    quiet = 1'b0;
  endtask

  // Longest frame: after it fires the countdown reloads with 65535, so it comes last.
  task automatic test_long_frame();
    setup(1'b1, 16'd65535, 4'd3, 16'd60000, 16'd60000, 16'd4000);
    repeat (6) send_sample(16'($urandom));
  endtask

  initial begin
    m_active = 1'b0; m_spf = 16'd22050; m_nchan = '0;
    m_frame_dmp = 16'd58982; m_amp_dmp = 16'd58982; m_gain = 16'd1;
    for (int i = 0; i < NumChan; i++) begin
      m_phase[i] = '0; m_step[i] = '0; m_re[i] = 0; m_im[i] = 0;
    end
    m_peak = '0; m_countdown = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_inactive();
    test_extremes();
    test_channel_count();
    test_bad_index();
    test_random(140, 4);
    test_long_frame();
    drain();
    $display("Sent %0d words, checked %0d results over %0d frames.",
             words_sent, results_seen, frames_seen);
    $display("Covered inactive, zero peak, full scale, channel caps, damping and gain limits.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
